[rtl/core/mhmd_pkg.sv]
// ----------------------------------------------------------------------------
// mhmd_pkg
// Shared operation codes, sequencer states and helpers for the HI/LO
// multiply/divide unit.
// ----------------------------------------------------------------------------
package mhmd_pkg;

  localparam int unsigned OP_W    = 4;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DWORD_W = 64;

  // Operation codes
  localparam logic [OP_W-1:0] OP_MULT  = 4'd0;
  localparam logic [OP_W-1:0] OP_MULTU = 4'd1;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd2;
  localparam logic [OP_W-1:0] OP_DIVU  = 4'd3;
  localparam logic [OP_W-1:0] OP_MADD  = 4'd4;
  localparam logic [OP_W-1:0] OP_MADDU = 4'd5;
  localparam logic [OP_W-1:0] OP_MFHI  = 4'd6;
  localparam logic [OP_W-1:0] OP_MFLO  = 4'd7;
  localparam logic [OP_W-1:0] OP_MTHI  = 4'd8;
  localparam logic [OP_W-1:0] OP_MTLO  = 4'd9;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_NEG_LO = 7'b0001000,
    S_NEG_HI = 7'b0010000,
    S_ACC    = 7'b0100000,
    S_DONE   = 7'b1000000
  } mhmd_state_t;

  // Sign-extend a 32-bit word to 64 bits
  function automatic logic [DWORD_W-1:0] sext32(input logic [WORD_W-1:0] x);
    return {{WORD_W{x[WORD_W-1]}}, x};
  endfunction

endpackage

[rtl/core/mhmd_in_if.sv]
// ----------------------------------------------------------------------------
// mhmd_in_if
// Request channel into the multiply/divide unit: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface mhmd_in_if;
  import mhmd_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic               pipe_select;
  logic [IDX_W-1:0]   dest_index;
  logic [DWORD_W-1:0] operand_a;
  logic [WORD_W-1:0]  operand_b;

  modport source (
    output valid, operation, pipe_select, dest_index, operand_a, operand_b,
    input  ready
  );

  modport sink (
    input  valid, operation, pipe_select, dest_index, operand_a, operand_b,
    output ready
  );
endinterface

[rtl/core/mhmd_out_if.sv]
// ----------------------------------------------------------------------------
// mhmd_out_if
// Result channel out of the multiply/divide unit: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface mhmd_out_if;
  import mhmd_pkg::*;

  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   dest_index_out;
  logic               dest_write;
  logic [DWORD_W-1:0] dest_value;

  modport source (
    output valid, dest_index_out, dest_write, dest_value,
    input  ready
  );

  modport sink (
    input  valid, dest_index_out, dest_write, dest_value,
    output ready
  );
endinterface

[rtl/core/mips_hilo_mult_div_unit.sv]
// ----------------------------------------------------------------------------
// mips_hilo_mult_div_unit
// 32-bit multiply/divide unit with two HI/LO register pairs.
// ----------------------------------------------------------------------------
// Takes one request at a time. Moves to and from HI/LO finish in the accept
// cycle and their result is visible on the next cycle. Multiplies and divides
// run through one shared 64-bit adder: 32 shift-add or restoring-subtract
// steps, then a negate step for each sign fix-up (product, quotient,
// remainder), the MADD accumulate step and the commit step. Divide by zero
// skips the loop and goes straight to commit. The 32-step adder loop sets
// the latency. A new request is taken once the unit is idle and the result
// register is empty or being drained.
// ----------------------------------------------------------------------------
module mips_hilo_mult_div_unit (
  input  logic        clk,
  input  logic        rst_n,
  mhmd_in_if.sink     in_ch,
  mhmd_out_if.source  out_ch
);
  import mhmd_pkg::*;

  // Sequencer and datapath registers
  mhmd_state_t        state_r, state_nxt;
  logic [4:0]         count_r, count_nxt;
  logic [DWORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0]  mcand_r, mcand_nxt;
  logic               neg_q_r, neg_q_nxt;
  logic               neg_r_r, neg_r_nxt;
  logic               is_div_r, is_div_nxt;
  logic               is_madd_r, is_madd_nxt;
  logic               pipe_r, pipe_nxt;
  logic [IDX_W-1:0]   dest_r, dest_nxt;

  // Architectural HI/LO pairs
  logic [DWORD_W-1:0] hi_r [2];
  logic [DWORD_W-1:0] lo_r [2];
  logic [DWORD_W-1:0] hi_nxt [2];
  logic [DWORD_W-1:0] lo_nxt [2];

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic               out_wr_r, out_wr_nxt;
  logic [DWORD_W-1:0] out_val_r, out_val_nxt;

  // Shared adder
  logic [DWORD_W-1:0] add_x, add_y, add_sum;
  logic               add_cin;

  logic               in_ready, accept, out_free;
  logic               op_signed;
  logic [WORD_W-1:0]  a_lo, mag_a, mag_b;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_ch.valid && in_ready;

  // Operand magnitudes for the signed forms
  assign a_lo      = in_ch.operand_a[WORD_W-1:0];
  assign op_signed = (in_ch.operation == OP_MULT) || (in_ch.operation == OP_MADD) ||
                     (in_ch.operation == OP_DIV);
  assign mag_a = (op_signed && a_lo[WORD_W-1]) ? (~a_lo + 32'd1) : a_lo;
  assign mag_b = (op_signed && in_ch.operand_b[WORD_W-1]) ?
                 (~in_ch.operand_b + 32'd1) : in_ch.operand_b;

  // Adder operand selection per sequencer state
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    case (state_r)
      S_MUL: begin
        add_x = {32'h0, acc_r[63:32]};
        add_y = acc_r[0] ? {32'h0, mcand_r} : '0;
      end
      S_DIV: begin
        add_x   = {31'h0, acc_r[63:31]};
        add_y   = ~{32'h0, mcand_r};
        add_cin = 1'b1;
      end
      S_NEG_LO: begin
        add_x   = is_div_r ? {32'h0, ~acc_r[31:0]} : ~acc_r;
        add_cin = 1'b1;
      end
      S_NEG_HI: begin
        add_x   = {32'h0, ~acc_r[63:32]};
        add_cin = 1'b1;
      end
      S_ACC: begin
        add_x = acc_r;
        add_y = {hi_r[pipe_r][31:0], lo_r[pipe_r][31:0]};
      end
      default: begin
        add_x   = '0;
      end
    endcase
  end

  assign add_sum = add_x + add_y + {63'h0, add_cin};

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    neg_q_nxt     = neg_q_r;
    neg_r_nxt     = neg_r_r;
    is_div_nxt    = is_div_r;
    is_madd_nxt   = is_madd_r;
    pipe_nxt      = pipe_r;
    dest_nxt      = dest_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_idx_nxt   = out_idx_r;
    out_wr_nxt    = out_wr_r;
    out_val_nxt   = out_val_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pipe_nxt    = in_ch.pipe_select;
          dest_nxt    = in_ch.dest_index;
          is_madd_nxt = (in_ch.operation == OP_MADD) || (in_ch.operation == OP_MADDU);
          is_div_nxt  = 1'b0;
          neg_r_nxt   = 1'b0;
          count_nxt   = 5'd31;
          // moves and undefined codes answer right away
          out_idx_nxt = in_ch.dest_index;
          out_wr_nxt  = 1'b0;
          out_val_nxt = '0;
          case (in_ch.operation)
            OP_MULT, OP_MULTU, OP_MADD, OP_MADDU: begin
              acc_nxt   = {32'h0, mag_b};
              mcand_nxt = mag_a;
              neg_q_nxt = op_signed && (a_lo[31] ^ in_ch.operand_b[31]);
              state_nxt = S_MUL;
            end
            OP_DIV, OP_DIVU: begin
              is_div_nxt = 1'b1;
              if (in_ch.operand_b == '0) begin
                // divide by zero: HI = dividend, LO = +1 / all ones
                acc_nxt   = {a_lo, (op_signed && a_lo[31]) ? 32'd1 : 32'hFFFF_FFFF};
                neg_q_nxt = 1'b0;
                state_nxt = S_DONE;
              end else begin
                acc_nxt   = {32'h0, mag_a};
                mcand_nxt = mag_b;
                neg_q_nxt = op_signed && (a_lo[31] ^ in_ch.operand_b[31]);
                neg_r_nxt = op_signed && a_lo[31];
                state_nxt = S_DIV;
              end
            end
            OP_MFHI: begin
              out_valid_nxt = 1'b1;
              out_wr_nxt    = (in_ch.dest_index != '0);
              out_val_nxt   = hi_r[in_ch.pipe_select];
            end
            OP_MFLO: begin
              out_valid_nxt = 1'b1;
              out_wr_nxt    = (in_ch.dest_index != '0);
              out_val_nxt   = lo_r[in_ch.pipe_select];
            end
            OP_MTHI: begin
              out_valid_nxt                = 1'b1;
              hi_nxt[in_ch.pipe_select]    = in_ch.operand_a;
            end
            OP_MTLO: begin
              out_valid_nxt                = 1'b1;
              lo_nxt[in_ch.pipe_select]    = in_ch.operand_a;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // Shift-add step on the magnitudes
      S_MUL: begin
        acc_nxt   = {add_sum[32:0], acc_r[31:1]};
        count_nxt = count_r - 5'd1;
        if (count_r == '0) begin
          if (neg_q_r)        state_nxt = S_NEG_LO;
          else if (is_madd_r) state_nxt = S_ACC;
          else                state_nxt = S_DONE;
        end
      end

      // Restoring divide step: keep the difference when it is not negative
      S_DIV: begin
        count_nxt = count_r - 5'd1;
        if (add_sum[63]) acc_nxt = {acc_r[62:0], 1'b0};
        else             acc_nxt = {add_sum[31:0], acc_r[30:0], 1'b1};
        if (count_r == '0) begin
          if (neg_q_r)      state_nxt = S_NEG_LO;
          else if (neg_r_r) state_nxt = S_NEG_HI;
          else              state_nxt = S_DONE;
        end
      end

      // Negate the product, or the quotient of a divide
      S_NEG_LO: begin
        if (is_div_r) begin
          acc_nxt   = {acc_r[63:32], add_sum[31:0]};
          state_nxt = neg_r_r ? S_NEG_HI : S_DONE;
        end else begin
          acc_nxt   = add_sum;
          state_nxt = is_madd_r ? S_ACC : S_DONE;
        end
      end

      // Negate the remainder
      S_NEG_HI: begin
        acc_nxt   = {add_sum[31:0], acc_r[31:0]};
        state_nxt = S_DONE;
      end

      // Add the low words of HI:LO
      S_ACC: begin
        acc_nxt   = add_sum;
        state_nxt = S_DONE;
      end

      // Commit HI/LO and post the result
      S_DONE: begin
        if (out_free) begin
          lo_nxt[pipe_r] = sext32(acc_r[31:0]);
          hi_nxt[pipe_r] = sext32(acc_r[63:32]);
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = dest_r;
          out_wr_nxt     = !is_div_r && (dest_r != '0);
          out_val_nxt    = is_div_r ? '0 : sext32(acc_r[31:0]);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hi_r[0]     <= '0;
      hi_r[1]     <= '0;
      lo_r[0]     <= '0;
      lo_r[1]     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hi_r        <= hi_nxt;
      lo_r        <= lo_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    count_r   <= count_nxt;
    acc_r     <= acc_nxt;
    mcand_r   <= mcand_nxt;
    neg_q_r   <= neg_q_nxt;
    neg_r_r   <= neg_r_nxt;
    is_div_r  <= is_div_nxt;
    is_madd_r <= is_madd_nxt;
    pipe_r    <= pipe_nxt;
    dest_r    <= dest_nxt;
    out_idx_r <= out_idx_nxt;
    out_wr_r  <= out_wr_nxt;
    out_val_r <= out_val_nxt;
  end

  // Channel outputs
  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.dest_index_out = out_idx_r;
  assign out_ch.dest_write     = out_wr_r;
  assign out_ch.dest_value     = out_val_r;

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == S_IDLE))
    else $error("request taken while busy");

  a_mul_loop_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) && (count_r == '0) |=> (state_r != S_MUL))
    else $error("multiply loop overran");

  a_div_zero_skip: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ((in_ch.operation == OP_DIV) || (in_ch.operation == OP_DIVU)) &&
    (in_ch.operand_b == '0) |=> (state_r == S_DONE))
    else $error("divide by zero entered the loop");

  a_done_posts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_free |=> out_valid_r && (state_r == S_IDLE))
    else $error("commit did not post a result");

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HI/LO multiply/divide unit. A short table of
// directed requests (reset values, operand extremes, divide overflow, divide
// by zero, moves, reserved codes) runs first. Random requests follow, biased
// so that arithmetic is often read back through mfhi/mflo. Every accepted
// request is run through a local model of both HI/LO pairs, and each
// writeback is checked field by field, in order. Sender bursts and receiver
// stalls are random, with one long receiver hold-off that backs up the unit.
// ----------------------------------------------------------------------------
module testbench;
  import mhmd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Reserved operation codes, no architectural effect
  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 4'd10;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 4'd15;

  localparam int NUM_RANDOM   = 1750;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLDOFF_AT   = 300;
  localparam int HOLDOFF_LEN  = 400;

  // One request plus an optional hand-typed writeback
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               pipe;
    logic [IDX_W-1:0]   idx;
    logic [DWORD_W-1:0] a;
    logic [WORD_W-1:0]  b;
    logic               typed;
    logic               exp_write;
    logic [DWORD_W-1:0] exp_value;
  } stim_row_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic               write;
    logic [DWORD_W-1:0] value;
  } writeback_t;

  typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_SPARSE} rx_mode_t;

  localparam int NUM_DIRECTED = 26;
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // reset values of both pairs
    '{OP_MFHI,  1'b0, 5'd1,  64'h0, 32'h0, 1'b1, 1'b1, 64'h0},
    '{OP_MFLO,  1'b1, 5'd31, 64'h0, 32'h0, 1'b1, 1'b1, 64'h0},
    // -1 * -1, upper operand bits ignored
    '{OP_MULT,  1'b0, 5'd5,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'd1},
    // largest unsigned product
    '{OP_MULTU, 1'b1, 5'd31, 64'h0000_0000_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'd1},
    '{OP_MFHI,  1'b1, 5'd2,  64'h0, 32'h0, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE},
    // index zero: no write, value still carried
    '{OP_MULT,  1'b0, 5'd0,  64'h0000_0000_7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, 64'd1},
    // signed overflow
    '{OP_DIV,   1'b0, 5'd9,  64'h0000_0000_8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 64'h0},
    '{OP_MFLO,  1'b0, 5'd3,  64'h0, 32'h0, 1'b1, 1'b1, 64'hFFFF_FFFF_8000_0000},
    '{OP_MFHI,  1'b0, 5'd4,  64'h0, 32'h0, 1'b1, 1'b1, 64'h0},
    // signed divide by zero, negative dividend
    '{OP_DIV,   1'b1, 5'd6,  64'hAAAA_AAAA_8000_0005, 32'h0, 1'b1, 1'b0, 64'h0},
    '{OP_MFLO,  1'b1, 5'd7,  64'h0, 32'h0, 1'b1, 1'b1, 64'd1},
    '{OP_MFHI,  1'b1, 5'd8,  64'h0, 32'h0, 1'b1, 1'b1, 64'hFFFF_FFFF_8000_0005},
    // signed divide by zero, positive dividend
    '{OP_DIV,   1'b0, 5'd0,  64'h0000_0000_0000_0005, 32'h0, 1'b1, 1'b0, 64'h0},
    '{OP_MFLO,  1'b0, 5'd10, 64'h0, 32'h0, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    // unsigned divide by zero
    '{OP_DIVU,  1'b1, 5'd11, 64'h5555_5555_1234_5678, 32'h0, 1'b1, 1'b0, 64'h0},
    '{OP_MFLO,  1'b1, 5'd12, 64'h0, 32'h0, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{OP_MFHI,  1'b1, 5'd13, 64'h0, 32'h0, 1'b1, 1'b1, 64'h0000_0000_1234_5678},
    // negative dividend, remainder keeps its sign
    '{OP_DIV,   1'b0, 5'd14, 64'h0000_0000_FFFF_FFF9, 32'd2, 1'b0, 1'b0, 64'h0},
    '{OP_MFHI,  1'b0, 5'd14, 64'h0, 32'h0, 1'b0, 1'b0, 64'h0},
    '{OP_MFLO,  1'b0, 5'd15, 64'h0, 32'h0, 1'b0, 1'b0, 64'h0},
    // full 64-bit moves, then accumulate on top
    '{OP_MTHI,  1'b1, 5'd16, 64'hDEAD_BEEF_0123_4567, 32'h0, 1'b1, 1'b0, 64'h0},
    '{OP_MTLO,  1'b1, 5'd17, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b1, 1'b0, 64'h0},
    '{OP_MADDU, 1'b1, 5'd18, 64'h0000_0000_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 64'h0},
    '{OP_MADD,  1'b0, 5'd19, 64'h0000_0000_8000_0000, 32'h8000_0000, 1'b0, 1'b0, 64'h0},
    // reserved codes
    '{OP_RSVD_FIRST, 1'b0, 5'd20, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 64'h0},
    '{OP_RSVD_LAST,  1'b1, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 64'h0}
  };

  logic clk = 1'b0;
  logic rst_n;

  mhmd_in_if  in_ch();
  mhmd_out_if out_ch();

  mips_hilo_mult_div_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Model state of the two pairs
  logic [DWORD_W-1:0] hi_reg [2];
  logic [DWORD_W-1:0] lo_reg [2];

  writeback_t  writeback_q [$];
  int unsigned err_count     = 0;
  int unsigned results_seen  = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  logic        readback_due  = 1'b0;
  logic        last_pipe     = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [DWORD_W-1:0] widen(input logic [WORD_W-1:0] w);
    return {{WORD_W{w[WORD_W-1]}}, w};
  endfunction

  // Split a 64-bit total into sign-extended LO and HI words
  function automatic void split_store(input logic p, input logic [DWORD_W-1:0] t);
    lo_reg[p] = widen(t[31:0]);
    hi_reg[p] = widen(t[63:32]);
  endfunction

  // Apply one request to the model pairs and return its writeback
  function automatic writeback_t mdu_exec(input logic [OP_W-1:0] op, input logic p,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [DWORD_W-1:0] a64,
                                          input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0]  a;
    logic [WORD_W-1:0]  mag_a;
    logic [WORD_W-1:0]  mag_b;
    logic [WORD_W-1:0]  quo;
    logic [WORD_W-1:0]  rem;
    logic [DWORD_W-1:0] prod;
    logic [DWORD_W-1:0] acc;
    logic               wants;
    writeback_t         res;
    a     = a64[31:0];
    wants = 1'b0;
    res   = '0;
    case (op)
      OP_MULT, OP_MULTU, OP_MADD, OP_MADDU: begin
        if (op == OP_MULT || op == OP_MADD) prod = widen(a) * widen(b);
        else prod = {32'h0, a} * {32'h0, b};
        if (op == OP_MADD || op == OP_MADDU) begin
          acc  = {hi_reg[p][31:0], lo_reg[p][31:0]};
          prod = prod + acc;
        end
        split_store(p, prod);
        wants     = 1'b1;
        res.value = lo_reg[p];
      end
      OP_DIV: begin
        if (b == '0) begin
          lo_reg[p] = a[31] ? 64'd1 : '1;
          hi_reg[p] = widen(a);
        end else begin
          mag_a = a[31] ? (32'h0 - a) : a;
          mag_b = b[31] ? (32'h0 - b) : b;
          quo   = mag_a / mag_b;
          rem   = mag_a % mag_b;
          if (a[31] ^ b[31]) quo = 32'h0 - quo;
          if (a[31]) rem = 32'h0 - rem;
          lo_reg[p] = widen(quo);
          hi_reg[p] = widen(rem);
        end
      end
      OP_DIVU: begin
        if (b == '0) begin
          lo_reg[p] = '1;
          hi_reg[p] = widen(a);
        end else begin
          lo_reg[p] = widen(a / b);
          hi_reg[p] = widen(a % b);
        end
      end
      OP_MFHI: begin
        wants     = 1'b1;
        res.value = hi_reg[p];
      end
      OP_MFLO: begin
        wants     = 1'b1;
        res.value = lo_reg[p];
      end
      OP_MTHI: hi_reg[p] = a64;
      OP_MTLO: lo_reg[p] = a64;
      default: ;
    endcase
    res.idx   = idx;
    res.write = wants && (idx != '0);
    return res;
  endfunction

  // Operand word with corner values mixed in
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return WORD_W'($urandom_range(1, 255));
      5: return 32'h0 - WORD_W'($urandom_range(1, 255));
      default: return $urandom();
    endcase
  endfunction

  // Random request; arithmetic is often followed by a read of the same pair
  function automatic stim_row_t random_request();
    stim_row_t r;
    r = '0;
    if (readback_due && $urandom_range(0, 1) == 1) begin
      r.op   = ($urandom_range(0, 1) == 1) ? OP_MFHI : OP_MFLO;
      r.pipe = last_pipe;
    end else begin
      if ($urandom_range(0, 15) == 0)
        r.op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
      else
        r.op = OP_W'($urandom_range(OP_MULT, OP_MTLO));
      r.pipe = 1'($urandom_range(0, 1));
    end
    r.idx = ($urandom_range(0, 7) == 0) ? '0 : IDX_W'($urandom_range(1, 31));
    r.a   = {$urandom(), pick_word()};
    r.b   = pick_word();
    readback_due = (r.op <= OP_MTLO) && (r.op != OP_MFHI) && (r.op != OP_MFLO);
    last_pipe    = r.pipe;
    return r;
  endfunction

  // Offer one request, wait for acceptance, queue its writeback
  task automatic send_request(input stim_row_t r);
    int unsigned gap;
    writeback_t  pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.operation   = r.op;
    in_ch.pipe_select = r.pipe;
    in_ch.dest_index  = r.idx;
    in_ch.operand_a   = r.a;
    in_ch.operand_b   = r.b;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pred = mdu_exec(r.op, r.pipe, r.idx, r.a, r.b);
    if (r.typed) writeback_q.push_back('{r.idx, r.exp_write, r.exp_value});
    else writeback_q.push_back(pred);
    @(negedge clk);
  endtask

  // Reset, directed table, random requests, drain, verdict
  initial begin : stimulus
    stim_row_t row;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = '0;
    in_ch.pipe_select = 1'b0;
    in_ch.dest_index  = '0;
    in_ch.operand_a   = '0;
    in_ch.operand_b   = '0;
    hi_reg            = '{default: '0};
    lo_reg            = '{default: '0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int i = 0; i < NUM_DIRECTED; i++) send_request(DIRECTED_ROWS[i]);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      row = random_request();
      send_request(row);
    end
    in_ch.valid = 1'b0;
    while (writeback_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: stall patterns, plus one long hold-off to back up the unit
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned holdoff_left;
    logic        holdoff_done;
    mode         = RX_STREAM;
    mode_left    = 0;
    holdoff_left = 0;
    holdoff_done = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (holdoff_left != 0) begin
        out_ch.ready = 1'b0;
        holdoff_left--;
      end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_LEN - 1;
        out_ch.ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          RX_STREAM: out_ch.ready = 1'b1;
          RX_RANDOM: out_ch.ready = 1'($urandom_range(0, 1));
          default:   out_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Writeback checker, in order
  always @(posedge clk) begin : check_writeback
    writeback_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (writeback_q.size() == 0) begin
        $error("writeback with nothing outstanding: idx %0d value %h",
               out_ch.dest_index_out, out_ch.dest_value);
        err_count++;
      end else begin
        want = writeback_q.pop_front();
        if (out_ch.dest_index_out !== want.idx) begin
          $error("dest_index_out: expected %0d, actual %0d", want.idx, out_ch.dest_index_out);
          err_count++;
        end
        if (out_ch.dest_write !== want.write) begin
          $error("dest_write: expected %0b, actual %0b", want.write, out_ch.dest_write);
          err_count++;
        end
        if (out_ch.dest_value !== want.value) begin
          $error("dest_value: expected %h, actual %h", want.value, out_ch.dest_value);
          err_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

[filelist.f]
rtl/core/mhmd_pkg.sv
rtl/core/mhmd_in_if.sv
rtl/core/mhmd_out_if.sv
rtl/core/mips_hilo_mult_div_unit.sv
dv/testbench.sv
